// ===== design/lbph_pkg.sv =====
// Shared types, constants and code-mapping functions for the LBP histogram block.
package lbph_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_COUNT_BITS = 32;

    localparam int CMD_W    = 2;
    localparam int PIXEL_W  = 8;
    localparam int BIN_W    = 8;
    localparam int OUT_W    = 32;
    localparam int MODE_W   = 2;
    localparam int IWIDTH_W = 11;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;
    localparam int NUM_BINS = 256;

    localparam logic [CMD_W-1:0] CMD_PIXEL = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FRAME = 2'd2;

    localparam logic [MODE_W-1:0] MODE_PLAIN   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_UNIFORM = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RIU     = 2'd2;

    localparam logic REG_MODE  = 1'b0;
    localparam logic REG_WIDTH = 1'b1;

    localparam logic [IWIDTH_W-1:0] RESET_WIDTH = 11'd1024;
    localparam logic [IWIDTH_W-1:0] MIN_WIDTH   = 11'd3;

    localparam logic [BIN_W-1:0] NONUNIFORM_BIN = 8'd58;
    localparam logic [8:0]       UNIFORM_BINS   = 9'd59;
    localparam logic [8:0]       RIU_BINS       = 9'd10;
    localparam logic [8:0]       PLAIN_BINS     = 9'd256;

    typedef logic [BIN_W-1:0] uni_lut_t [NUM_BINS];
    typedef logic [PIXEL_W-1:0] window_t [9];

    function automatic logic [3:0] lbph_transitions(input logic [7:0] code);
        logic [7:0] diff;
        logic [3:0] n;
        diff = code ^ {code[0], code[7:1]};
        n = 4'd0;
        for (int i = 0; i < 8; i++)
        begin
            n = n + 4'(diff[i]);
        end
        return n;
    endfunction

    function automatic logic [3:0] lbph_ones(input logic [7:0] code);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < 8; i++)
        begin
            n = n + 4'(code[i]);
        end
        return n;
    endfunction

    function automatic uni_lut_t build_uni_lut();
        uni_lut_t lut;
        logic [BIN_W-1:0] idx;
        idx = '0;
        for (int v = 0; v < NUM_BINS; v++)
        begin
            if (lbph_transitions(8'(v)) <= 4'd2)
            begin
                lut[v] = idx;
                idx    = idx + 8'd1;
            end
            else
            begin
                lut[v] = NONUNIFORM_BIN;
            end
        end
        return lut;
    endfunction

    localparam uni_lut_t UNI_LUT = build_uni_lut();

    function automatic logic [8:0] lbph_bins(input logic [MODE_W-1:0] mode);
        logic [8:0] n;
        unique case (mode)
            MODE_UNIFORM: n = UNIFORM_BINS;
            MODE_RIU:     n = RIU_BINS;
            default:      n = PLAIN_BINS;
        endcase
        return n;
    endfunction

endpackage

// ===== design/lbph_item_if.sv =====
// Input item channel: command, pixel and bin index with valid/ready.
interface lbph_item_if
    import lbph_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     command;
    logic [PIXEL_W-1:0]   pixel;
    logic [BIN_W-1:0]     bin_index;

    modport source (output valid, command, pixel, bin_index, input ready);
    modport sink   (input valid, command, pixel, bin_index, output ready);
endinterface

// ===== design/lbph_result_if.sv =====
// Result channel: bin count and interior pixel total with valid/ready.
interface lbph_result_if
    import lbph_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] bin_count;
    logic [OUT_W-1:0] interior_total;

    modport source (output valid, bin_count, interior_total, input ready);
    modport sink   (input valid, bin_count, interior_total, output ready);
endinterface

// ===== design/lbph_code_map.sv =====
// Local binary pattern code from a 3x3 window and its mapping to a histogram bin.
module lbph_code_map
    import lbph_pkg::*;
(
    input  window_t           win,
    input  logic [MODE_W-1:0] mode,
    output logic [BIN_W-1:0]  bin
);

    logic [7:0]         code;
    logic [PIXEL_W-1:0] centre;
    logic [3:0]         trans;

    always_comb
    begin
        centre  = win[4];
        code[0] = win[1] > centre;
        code[1] = win[2] > centre;
        code[2] = win[5] > centre;
        code[3] = win[8] > centre;
        code[4] = win[7] > centre;
        code[5] = win[6] > centre;
        code[6] = win[3] > centre;
        code[7] = win[0] > centre;
        trans   = lbph_transitions(code);
        unique case (mode)
            MODE_UNIFORM: bin = UNI_LUT[code];
            MODE_RIU:     bin = (trans <= 4'd2) ? BIN_W'(lbph_ones(code))
                                                : BIN_W'(RIU_BINS - 9'd1);
            default:      bin = code;
        endcase
    end

endmodule

// ===== design/lbp_histogram_3x3_top.sv =====
// LBP histogram top level: line memory, 3x3 window, bin memory and APB registers.
// Pixel on an interior position: accept, line update, code and bin read, bin update.
// Pixel on a border position: accept, line update; new frame and unused command: accept only.
// Read command: accept with bin read, then S_READ loads the result once the last is taken.
// Items are accepted only in S_IDLE, after read-modify-write of the single-port memories.
// Reset: async active low; a clearing pass over all MAX_WIDTH columns zeroes the line memory.
module lbp_histogram_3x3_top
    import lbph_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int COUNT_BITS = DEF_COUNT_BITS
)
(
    input  logic                clk,
    input  logic                rst_n,
    lbph_item_if.sink           item,
    lbph_result_if.source       result,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready
);

    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int AW    = (COL_W + 1 > IWIDTH_W) ? COL_W + 1 : IWIDTH_W;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_LINE  = 6'b000100,
        S_CODE  = 6'b001000,
        S_INC   = 6'b010000,
        S_READ  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [MODE_W-1:0]   mode_reg;
    logic [IWIDTH_W-1:0] width_reg;

    logic [2*PIXEL_W-1:0] line_mem [MAX_WIDTH];
    logic [2*PIXEL_W-1:0] line_rdata_reg;
    logic [COUNT_BITS-1:0] bin_mem [NUM_BINS];
    logic [COUNT_BITS-1:0] bin_rdata_reg;
    logic [NUM_BINS-1:0]   bin_valid_reg;

    window_t              win_reg;
    logic [COL_W-1:0]     col_reg;
    logic [COL_W-1:0]     clr_reg;
    logic [1:0]           row_reg;
    logic [COUNT_BITS-1:0] total_reg;
    logic [PIXEL_W-1:0]   px_reg;
    logic [BIN_W-1:0]     bin_addr_reg;

    logic             out_valid_reg;
    logic [OUT_W-1:0] bin_count_reg;
    logic [OUT_W-1:0] total_out_reg;

    logic             accept;
    logic             cfg_write;
    logic [BIN_W-1:0] mapped_bin;
    logic [AW-1:0]    act_width;
    logic [AW-1:0]    iw_ext;
    logic             row_end;
    logic             interior;
    logic             bin_rd_en;
    logic [BIN_W-1:0] bin_rd_addr;
    logic [COUNT_BITS-1:0] cur_count;
    logic [COUNT_BITS-1:0] rd_count;
    logic             out_load;

    function automatic logic [OUT_W-1:0] sat_out(input logic [COUNT_BITS-1:0] v);
        return (v > COUNT_BITS'(32'hFFFF_FFFF)) ? '1 : OUT_W'(v);
    endfunction

    lbph_code_map u_code_map
    (
        .win  (win_reg),
        .mode (mode_reg),
        .bin  (mapped_bin)
    );

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_WIDTH) ? APB_DW'(width_reg) : APB_DW'(mode_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_PLAIN;
            width_reg <= RESET_WIDTH;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_MODE)
            begin
                mode_reg <= pwdata[MODE_W-1:0];
            end
            else
            begin
                width_reg <= pwdata[IWIDTH_W-1:0];
            end
        end
    end

    assign item.ready = (state_reg == S_IDLE);
    assign accept     = item.valid && item.ready;

    always_comb
    begin
        iw_ext = AW'(width_reg);
        if (iw_ext < AW'(MIN_WIDTH))
        begin
            act_width = AW'(MIN_WIDTH);
        end
        else if (iw_ext > AW'(MAX_WIDTH))
        begin
            act_width = AW'(MAX_WIDTH);
        end
        else
        begin
            act_width = iw_ext;
        end
        row_end  = (AW'(col_reg) + AW'(1)) >= act_width;
        interior = (row_reg == 2'd2) && (col_reg >= COL_W'(2));
    end

    always_comb
    begin
        bin_rd_en   = 1'b0;
        bin_rd_addr = mapped_bin;
        if (accept && item.command == CMD_READ)
        begin
            bin_rd_en   = 1'b1;
            bin_rd_addr = item.bin_index;
        end
        else if (state_reg == S_CODE)
        begin
            bin_rd_en   = 1'b1;
            bin_rd_addr = mapped_bin;
        end
    end

    assign cur_count = bin_valid_reg[bin_addr_reg] ? bin_rdata_reg : '0;
    assign rd_count  = ({1'b0, bin_addr_reg} < lbph_bins(mode_reg)) ? cur_count : '0;
    assign out_load  = (state_reg == S_READ) && (!out_valid_reg || result.ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == COL_W'(MAX_WIDTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept && item.command == CMD_PIXEL)
                begin
                    state_next = S_LINE;
                end
                else if (accept && item.command == CMD_READ)
                begin
                    state_next = S_READ;
                end
            end
            S_LINE:  state_next = interior ? S_CODE : S_IDLE;
            S_CODE:  state_next = S_INC;
            S_INC:   state_next = S_IDLE;
            S_READ:  state_next = out_load ? S_IDLE : S_READ;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // line memory: both buffered rows of one column in one word
    always_ff @(posedge clk)
    begin
        if (state_reg == S_CLEAR)
        begin
            line_mem[clr_reg] <= '0;
        end
        else if (state_reg == S_LINE)
        begin
            line_mem[col_reg] <= {line_rdata_reg[PIXEL_W-1:0], px_reg};
        end
        if (accept && item.command == CMD_PIXEL)
        begin
            line_rdata_reg <= line_mem[col_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_INC)
        begin
            bin_mem[bin_addr_reg] <= (cur_count == '1) ? cur_count : cur_count + 1'b1;
        end
        if (bin_rd_en)
        begin
            bin_rdata_reg <= bin_mem[bin_rd_addr];
            bin_addr_reg  <= bin_rd_addr;
        end
        if (accept)
        begin
            px_reg <= item.pixel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            total_reg     <= '0;
            bin_valid_reg <= '0;
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            if (state_reg == S_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (accept && item.command == CMD_FRAME)
            begin
                bin_valid_reg <= '0;
                total_reg     <= '0;
                col_reg       <= '0;
                row_reg       <= '0;
            end
            if (state_reg == S_LINE)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    win_reg[r*3]   <= win_reg[r*3+1];
                    win_reg[r*3+1] <= win_reg[r*3+2];
                end
                win_reg[2] <= line_rdata_reg[2*PIXEL_W-1:PIXEL_W];
                win_reg[5] <= line_rdata_reg[PIXEL_W-1:0];
                win_reg[8] <= px_reg;
                if (row_end)
                begin
                    col_reg <= '0;
                    if (row_reg != 2'd2)
                    begin
                        row_reg <= row_reg + 2'd1;
                    end
                end
                else
                begin
                    col_reg <= col_reg + 1'b1;
                end
            end
            if (state_reg == S_INC)
            begin
                bin_valid_reg[bin_addr_reg] <= 1'b1;
                if (total_reg != '1)
                begin
                    total_reg <= total_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            bin_count_reg <= sat_out(rd_count);
            total_out_reg <= sat_out(total_reg);
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.bin_count      = bin_count_reg;
    assign result.interior_total = total_out_reg;

    a_out_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_READ)
        else $error("result raised without a read");

    a_inc_after_code: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_INC |-> $past(state_reg) == S_CODE)
        else $error("bin update without code stage");

    a_frame_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.command == CMD_FRAME |=> total_reg == '0 && bin_valid_reg == '0)
        else $error("new frame did not clear histogram");

endmodule
